### rtl/afa_pkg.sv
// ----------------------------------------------------------------------------
// afa_pkg
// Shared types and constants of the attractor force accumulator.
// ----------------------------------------------------------------------------
package afa_pkg;

	localparam int MAX_ATTRACTORS_DEF = 16;
	localparam int POS_W    = 32;
	localparam int MASS_W   = 16;
	localparam int TS_W     = 16;
	localparam int GAIN_W   = 16;
	localparam int FORCE_W  = 48;
	localparam int USED_W   = 5;
	localparam int DIFF_W   = 33;
	localparam int SSQ_W    = 66;
	localparam int ROOT_W   = 33;
	localparam int QUOT_W   = 17;
	localparam int TERM_W   = 43;
	localparam int CNT_W    = 6;
	localparam int SQRT_STEPS = 33;
	localparam int DIV_STEPS  = 17;
	localparam int FIN_LO_W   = 24;

	localparam logic [15:0] GAIN_RESET = 16'd256;

	// register indexes
	localparam logic [1:0] REG_GAIN_X = 2'd0;
	localparam logic [1:0] REG_GAIN_Y = 2'd1;
	localparam logic [1:0] REG_GAIN_Z = 2'd2;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_QUERY  = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SLOT,
		ST_SQ,
		ST_SQRT,
		ST_DIV,
		ST_MUL1,
		ST_MUL2,
		ST_ACC,
		ST_FIN1,
		ST_FIN2
	} state_t;

	typedef struct packed {
		logic signed [POS_W-1:0] px;
		logic signed [POS_W-1:0] py;
		logic signed [POS_W-1:0] pz;
		logic [MASS_W-1:0]       mass;
		logic [TS_W-1:0]         ts;
	} body_t;

	typedef struct packed {
		logic                    valid;
		logic signed [POS_W-1:0] px;
		logic signed [POS_W-1:0] py;
		logic signed [POS_W-1:0] pz;
		logic [MASS_W-1:0]       mass;
	} entry_t;

	typedef struct packed {
		logic busy;
		logic q_empty;
		logic q_full;
	} status_t;

endpackage

### rtl/afa_front.sv
// ----------------------------------------------------------------------------
// afa_front
// Accepts input beats, keeps the attractor table and forwards queries.
// ----------------------------------------------------------------------------
module afa_front import afa_pkg::*; #(
	parameter int MAX_ATTRACTORS = MAX_ATTRACTORS_DEF,
	localparam int IW = (MAX_ATTRACTORS > 1) ? $clog2(MAX_ATTRACTORS) : 1
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [1:0]              command,
	input  logic [3:0]              slot,
	input  logic signed [POS_W-1:0] pos_x,
	input  logic signed [POS_W-1:0] pos_y,
	input  logic signed [POS_W-1:0] pos_z,
	input  logic [MASS_W-1:0]       mass,
	input  logic [TS_W-1:0]         time_step,
	input  status_t                 status,
	output logic                    push,
	output body_t                   push_body,
	input  logic [IW-1:0]           rd_idx,
	output entry_t                  rd_entry
);

	logic [MAX_ATTRACTORS-1:0] valid_q;
	logic signed [POS_W-1:0]   tpx_q [MAX_ATTRACTORS];
	logic signed [POS_W-1:0]   tpy_q [MAX_ATTRACTORS];
	logic signed [POS_W-1:0]   tpz_q [MAX_ATTRACTORS];
	logic [MASS_W-1:0]         tm_q  [MAX_ATTRACTORS];

	logic          is_tab;
	logic          accept;
	logic          slot_ok;
	logic [IW-1:0] widx;

	// table commands wait until no query is pending
	assign is_tab   = (command == CMD_INSERT) || (command == CMD_REMOVE);
	assign in_stall = (is_tab && (status.busy || !status.q_empty))
		|| ((command == CMD_QUERY) && status.q_full);
	assign accept   = in_valid && !in_stall;
	assign slot_ok  = 32'(slot) < MAX_ATTRACTORS;
	assign widx     = IW'(slot);

	assign push = accept && (command == CMD_QUERY);
	assign push_body = '{px: pos_x, py: pos_y, pz: pos_z, mass: mass, ts: time_step};

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (accept && is_tab && slot_ok) begin
			valid_q[widx] <= (command == CMD_INSERT);
		end
	end

	// table payload
	always_ff @(posedge clk) begin
		if (accept && (command == CMD_INSERT) && slot_ok) begin
			tpx_q[widx] <= pos_x;
			tpy_q[widx] <= pos_y;
			tpz_q[widx] <= pos_z;
			tm_q[widx]  <= mass;
		end
	end

	assign rd_entry = '{valid: valid_q[rd_idx], px: tpx_q[rd_idx], py: tpy_q[rd_idx],
		pz: tpz_q[rd_idx], mass: tm_q[rd_idx]};

endmodule

### rtl/afa_queue.sv
// ----------------------------------------------------------------------------
// afa_queue
// Two-entry queue of pending queries between front and back.
// ----------------------------------------------------------------------------
module afa_queue import afa_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  body_t push_body,
	input  logic  pop,
	output logic  empty,
	output logic  full,
	output body_t head
);

	body_t      mem_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign empty = (cnt_q == 2'd0);
	assign full  = (cnt_q == 2'd2);
	assign head  = mem_q[rp_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop)  rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_body;
	end

endmodule

### rtl/afa_back.sv
// ----------------------------------------------------------------------------
// afa_back
// Walks the table for one query: distance, root, unit vector, products, sum.
// ----------------------------------------------------------------------------
module afa_back import afa_pkg::*; #(
	parameter int MAX_ATTRACTORS = MAX_ATTRACTORS_DEF,
	localparam int IW = (MAX_ATTRACTORS > 1) ? $clog2(MAX_ATTRACTORS) : 1,
	localparam int CW = $clog2(MAX_ATTRACTORS + 1),
	localparam int SUM_W = TERM_W + CW,
	localparam int HI_W = SUM_W - FIN_LO_W,
	localparam int FW = SUM_W + TS_W + 1
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic signed [GAIN_W-1:0] gain [3],
	input  logic                     q_empty,
	input  body_t                    q_head,
	output logic                     pop,
	output logic                     busy,
	output logic [IW-1:0]            rd_idx,
	input  entry_t                   rd_entry,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [FORCE_W-1:0] force_x,
	output logic signed [FORCE_W-1:0] force_y,
	output logic signed [FORCE_W-1:0] force_z,
	output logic [USED_W-1:0]        attractors_used
);

	localparam logic signed [63:0] F_MAX = 64'sd140737488355327;
	localparam logic signed [63:0] F_MIN = -64'sd140737488355328;

	state_t state_q, state_d;

	logic [IW-1:0]             idx_q;
	logic [1:0]                ax_q;
	logic [CNT_W-1:0]          cnt_q;
	body_t                     body_q;
	logic signed [DIFF_W-1:0]  d_q    [3];
	logic [2*MASS_W-1:0]       mm_q;
	logic [SSQ_W-1:0]          ssq_q;
	logic [ROOT_W:0]           rem_q;
	logic [ROOT_W-1:0]         root_q;
	logic [ROOT_W:0]           dr_q   [3];
	logic [QUOT_W-1:0]         dq_q   [3];
	logic signed [34:0]        q1_q   [3];
	logic signed [TERM_W-1:0]  term_q [3];
	logic signed [SUM_W-1:0]   sum_q  [3];
	logic [CW-1:0]             used_q;
	logic [FIN_LO_W+TS_W-1:0]  plo_q  [3];
	logic signed [HI_W+TS_W:0] phi_q  [3];
	logic                      out_valid_q;
	logic signed [FORCE_W-1:0] fo_q   [3];
	logic [USED_W-1:0]         used_out_q;

	logic                      last_slot;
	logic                      out_free;
	logic [DIFF_W-1:0]         mag    [3];
	logic [DIFF_W-1:0]         sq_mag;
	logic [SSQ_W-1:0]          sq_prod;
	logic [ROOT_W+2:0]         sr_n;
	logic [ROOT_W+2:0]         sr_t;
	logic                      sr_ge;
	logic [ROOT_W+1:0]         dv_t   [3];
	logic                      dv_ge  [3];
	logic signed [QUOT_W:0]    u      [3];
	logic signed [50:0]        p1     [3];
	logic signed [50:0]        p2     [3];
	logic signed [FW-1:0]      f_full [3];
	logic signed [63:0]        f_ext  [3];
	logic signed [FORCE_W-1:0] f_sat  [3];

	assign last_slot = (32'(idx_q) == MAX_ATTRACTORS - 1);
	assign out_free  = !out_valid_q || !out_stall;
	assign rd_idx    = idx_q;
	assign busy      = (state_q != ST_IDLE);
	assign pop       = (state_q == ST_IDLE) && !q_empty;

	// per-axis datapath
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			mag[a]   = d_q[a][DIFF_W-1] ? DIFF_W'(-d_q[a]) : DIFF_W'(d_q[a]);
			dv_t[a]  = {dr_q[a], (cnt_q == '0) ? mag[a][0] : 1'b0};
			dv_ge[a] = dv_t[a] >= {1'b0, 1'b0, root_q};
			u[a]     = d_q[a][DIFF_W-1] ? -$signed({1'b0, dq_q[a]}) : $signed({1'b0, dq_q[a]});
			p1[a]    = $signed({1'b0, mm_q}) * u[a];
			p2[a]    = q1_q[a] * gain[a];
			f_full[a] = ($signed(FW'(phi_q[a])) <<< FIN_LO_W) + $signed(FW'({1'b0, plo_q[a]}));
			f_ext[a] = 64'($signed(f_full[a][FW-1:16]));
			if (f_ext[a] > F_MAX)      f_sat[a] = F_MAX[FORCE_W-1:0];
			else if (f_ext[a] < F_MIN) f_sat[a] = F_MIN[FORCE_W-1:0];
			else                       f_sat[a] = f_ext[a][FORCE_W-1:0];
		end
	end

	// squaring and root step
	always_comb begin
		unique case (ax_q)
			2'd0:    sq_mag = mag[0];
			2'd1:    sq_mag = mag[1];
			default: sq_mag = mag[2];
		endcase
		sq_prod = SSQ_W'(sq_mag * sq_mag);
		sr_n    = {rem_q, ssq_q[SSQ_W-1:SSQ_W-2]};
		sr_t    = {1'b0, root_q, 2'b01};
		sr_ge   = sr_n >= sr_t;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (!q_empty) state_d = ST_SLOT;
			ST_SLOT: if (rd_entry.valid) state_d = ST_SQ;
				else if (last_slot) state_d = ST_FIN1;
			ST_SQ:   if (ax_q == 2'd2) state_d = ST_SQRT;
			ST_SQRT: if (32'(cnt_q) == SQRT_STEPS - 1) state_d = ST_DIV;
			ST_DIV:  if (root_q == '0) state_d = last_slot ? ST_FIN1 : ST_SLOT;
				else if (32'(cnt_q) == DIV_STEPS - 1) state_d = ST_MUL1;
			ST_MUL1: state_d = ST_MUL2;
			ST_MUL2: state_d = ST_ACC;
			ST_ACC:  state_d = last_slot ? ST_FIN1 : ST_SLOT;
			ST_FIN1: state_d = ST_FIN2;
			ST_FIN2: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			ax_q        <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// result beat: load when the register is free, drop when taken
			if (state_q == ST_FIN2 && out_free) out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: idx_q <= '0;
				ST_SLOT: begin
					ax_q <= '0;
					if (!rd_entry.valid && !last_slot) idx_q <= idx_q + 1'b1;
				end
				ST_SQ:   begin
					ax_q  <= ax_q + 2'd1;
					cnt_q <= '0;
				end
				ST_SQRT: cnt_q <= (32'(cnt_q) == SQRT_STEPS - 1) ? '0 : cnt_q + 1'b1;
				ST_DIV:  begin
					cnt_q <= cnt_q + 1'b1;
					if (root_q == '0 && !last_slot) idx_q <= idx_q + 1'b1;
				end
				ST_ACC:  if (!last_slot) idx_q <= idx_q + 1'b1;
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				body_q <= q_head;
				used_q <= '0;
				for (int a = 0; a < 3; a++) sum_q[a] <= '0;
			end
			ST_SLOT: begin
				d_q[0] <= DIFF_W'(rd_entry.px) - DIFF_W'(body_q.px);
				d_q[1] <= DIFF_W'(rd_entry.py) - DIFF_W'(body_q.py);
				d_q[2] <= DIFF_W'(rd_entry.pz) - DIFF_W'(body_q.pz);
				mm_q   <= rd_entry.mass * body_q.mass;
				ssq_q  <= '0;
				rem_q  <= '0;
				root_q <= '0;
			end
			ST_SQ: ssq_q <= ssq_q + sq_prod;
			ST_SQRT: begin
				ssq_q  <= ssq_q << 2;
				rem_q  <= sr_ge ? (ROOT_W+1)'(sr_n - sr_t) : (ROOT_W+1)'(sr_n);
				root_q <= {root_q[ROOT_W-2:0], sr_ge};
				for (int a = 0; a < 3; a++) begin
					dr_q[a] <= (ROOT_W+1)'(mag[a] >> 1);
					dq_q[a] <= '0;
				end
			end
			ST_DIV: begin
				for (int a = 0; a < 3; a++) begin
					dr_q[a] <= dv_ge[a] ? (ROOT_W+1)'(dv_t[a] - {2'b0, root_q})
						: (ROOT_W+1)'(dv_t[a]);
					dq_q[a] <= {dq_q[a][QUOT_W-2:0], dv_ge[a]};
				end
			end
			ST_MUL1: for (int a = 0; a < 3; a++) q1_q[a] <= p1[a][50:16];
			ST_MUL2: for (int a = 0; a < 3; a++) term_q[a] <= p2[a][50:8];
			ST_ACC: begin
				for (int a = 0; a < 3; a++) sum_q[a] <= sum_q[a] + SUM_W'(term_q[a]);
				used_q <= used_q + 1'b1;
			end
			ST_FIN1: begin
				for (int a = 0; a < 3; a++) begin
					plo_q[a] <= sum_q[a][FIN_LO_W-1:0] * body_q.ts;
					phi_q[a] <= $signed(sum_q[a][SUM_W-1:FIN_LO_W]) * $signed({1'b0, body_q.ts});
				end
			end
			ST_FIN2: if (out_free) begin
				for (int a = 0; a < 3; a++) fo_q[a] <= f_sat[a];
				used_out_q <= USED_W'(used_q);
			end
			default: ;
		endcase
	end

	assign out_valid       = out_valid_q;
	assign force_x         = fo_q[0];
	assign force_y         = fo_q[1];
	assign force_z         = fo_q[2];
	assign attractors_used = used_out_q;

endmodule

### rtl/attractor_force_accumulator.sv
// ----------------------------------------------------------------------------
// attractor_force_accumulator
// Table of attractors with a query engine summing unit attraction forces.
// ----------------------------------------------------------------------------
// query steps per valid slot: squaring of the three axes, a 33-step root and, unless the
// distance is zero, a 17-step divide; empty slots are skipped
// one query in the engine at a time; the next is popped in idle after a result is loaded
// insert and remove wait until no query is pending
// up to two queries queue while the engine works; results hold in an output register
// reset clears the valid bits and sets the gains to 1.0; no clearing pass
module attractor_force_accumulator import afa_pkg::*; #(
	parameter int MAX_ATTRACTORS = MAX_ATTRACTORS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [3:0]                paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [1:0]                command,
	input  logic [3:0]                slot,
	input  logic signed [POS_W-1:0]   pos_x,
	input  logic signed [POS_W-1:0]   pos_y,
	input  logic signed [POS_W-1:0]   pos_z,
	input  logic [MASS_W-1:0]         mass,
	input  logic [TS_W-1:0]           time_step,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [FORCE_W-1:0] force_x,
	output logic signed [FORCE_W-1:0] force_y,
	output logic signed [FORCE_W-1:0] force_z,
	output logic [USED_W-1:0]         attractors_used
);

	localparam int IW = (MAX_ATTRACTORS > 1) ? $clog2(MAX_ATTRACTORS) : 1;

	logic signed [GAIN_W-1:0] gain_q [3];
	status_t                  status;
	logic                     push;
	body_t                    push_body;
	logic                     pop;
	body_t                    q_head;
	logic                     busy;
	logic                     q_empty;
	logic                     q_full;
	logic [IW-1:0]            rd_idx;
	entry_t                   rd_entry;

	// register port
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < 3; a++) gain_q[a] <= GAIN_RESET;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				REG_GAIN_X: gain_q[0] <= pwdata[15:0];
				REG_GAIN_Y: gain_q[1] <= pwdata[15:0];
				REG_GAIN_Z: gain_q[2] <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_GAIN_X: prdata = 32'($signed(gain_q[0]));
			REG_GAIN_Y: prdata = 32'($signed(gain_q[1]));
			REG_GAIN_Z: prdata = 32'($signed(gain_q[2]));
			default:    prdata = '0;
		endcase
	end

	assign status = '{busy: busy, q_empty: q_empty, q_full: q_full};

	afa_front #(.MAX_ATTRACTORS(MAX_ATTRACTORS)) u_front (
		.clk, .arst_n, .in_valid, .in_stall, .command, .slot,
		.pos_x, .pos_y, .pos_z, .mass, .time_step,
		.status, .push, .push_body, .rd_idx, .rd_entry
	);

	afa_queue u_queue (
		.clk, .arst_n, .push, .push_body, .pop,
		.empty(q_empty), .full(q_full), .head(q_head)
	);

	afa_back #(.MAX_ATTRACTORS(MAX_ATTRACTORS)) u_back (
		.clk, .arst_n, .gain(gain_q), .q_empty, .q_head, .pop, .busy,
		.rd_idx, .rd_entry, .out_valid, .out_stall,
		.force_x, .force_y, .force_z, .attractors_used
	);

endmodule
